/* rtl/tpsq_pkg.sv */
// Shared types, widths and codes for the trajectory point store.
// Used by tpsq_scan_unit and trajectory_point_store_query; no dependencies.
package tpsq_pkg;

    localparam int DEFAULT_MAX_POINTS = 1024;

    localparam int TIME_W      = 32;
    localparam int POS_W       = 24;
    localparam int INDEX_W     = 10;
    localparam int COUNT_OUT_W = 11;
    localparam int EPS_W       = 20;
    localparam int BUF_W       = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 40;

    localparam int DIFF_W = POS_W + 1;         // dx, dy
    localparam int SQ_W   = 2 * POS_W + 1;     // dx*dx
    localparam int DIST_W = 2 * POS_W + 2;     // dx*dx + dy*dy
    localparam int PT_W   = TIME_W + 2 * POS_W; // packed RAM word

    typedef enum logic [1:0] {
        K_APPEND  = 2'd0,
        K_NEAREST = 2'd1,
        K_TIME    = 2'd2,
        K_CLEAR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_ORDER = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_EPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUF = 2'd1;

    // sequencer -> scan unit
    typedef struct packed {
        logic init;     // start of a query: forget previous winner
        logic valid;    // a point word is on the data inputs
        logic nearest;  // 1: nearest search, 0: time lower bound
    } scan_ctl_t;

    // scan unit -> sequencer
    typedef struct packed {
        logic busy;     // points still in flight
        logic found;    // a winner has been latched
    } scan_sts_t;

endpackage

/* rtl/tpsq_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module tpsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/tpsq_scan_unit.sv */
// Shared per-point scan datapath: distance/time compare pipeline and winner.
// Depends on tpsq_pkg.
module tpsq_scan_unit #(
    parameter int AW = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tpsq_pkg::scan_ctl_t                   ctl,
    input  logic [AW-1:0]                         pt_idx,
    input  logic signed [tpsq_pkg::TIME_W-1:0]    pt_time,
    input  logic signed [tpsq_pkg::POS_W-1:0]     pt_x,
    input  logic signed [tpsq_pkg::POS_W-1:0]     pt_y,
    input  logic signed [tpsq_pkg::TIME_W-1:0]    q_time,
    input  logic signed [tpsq_pkg::POS_W-1:0]     q_x,
    input  logic signed [tpsq_pkg::POS_W-1:0]     q_y,
    input  logic [tpsq_pkg::EPS_W-1:0]            eps,
    input  logic [tpsq_pkg::BUF_W-1:0]            slack,
    output tpsq_pkg::scan_sts_t                   sts,
    output logic [AW-1:0]                         win_idx
);

    localparam int TW = tpsq_pkg::TIME_W;

    // stage 1: differences and time test
    logic                                 v1_reg, v1_next;
    logic [AW-1:0]                        idx1_reg;
    logic signed [tpsq_pkg::DIFF_W-1:0]   dx1_reg, dy1_reg, dx1_next, dy1_next;
    logic                                 hit1_reg, hit1_next;
    // stage 2: squares
    logic                                 v2_reg;
    logic [AW-1:0]                        idx2_reg;
    logic [tpsq_pkg::SQ_W-1:0]            sqx2_reg, sqy2_reg, sqx2_next, sqy2_next;
    logic                                 hit2_reg;
    // stage 3: distance
    logic                                 v3_reg;
    logic [AW-1:0]                        idx3_reg;
    logic [tpsq_pkg::DIST_W-1:0]          d3_reg, d3_next;
    logic                                 hit3_reg;
    // winner
    logic                                 have_reg, have_next;
    logic [tpsq_pkg::DIST_W-1:0]          best_reg, best_next;
    logic [AW-1:0]                        win_reg, win_next;

    logic signed [TW:0]                   t_sum;
    logic signed [2*tpsq_pkg::DIFF_W-1:0] px, py;
    logic [tpsq_pkg::DIST_W:0]            thresh;

    always_comb
    begin
        v1_next  = ctl.valid;
        dx1_next = {pt_x[tpsq_pkg::POS_W-1], pt_x} - {q_x[tpsq_pkg::POS_W-1], q_x};
        dy1_next = {pt_y[tpsq_pkg::POS_W-1], pt_y} - {q_y[tpsq_pkg::POS_W-1], q_y};
        t_sum    = {pt_time[TW-1], pt_time}
                 + $signed({{(TW + 1 - tpsq_pkg::EPS_W){1'b0}}, eps});
        hit1_next = t_sum >= $signed({q_time[TW-1], q_time});

        px = dx1_reg * dx1_reg;
        py = dy1_reg * dy1_reg;
        sqx2_next = px[tpsq_pkg::SQ_W-1:0];
        sqy2_next = py[tpsq_pkg::SQ_W-1:0];

        d3_next = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};

        thresh    = {1'b0, best_reg}
                  + {{(tpsq_pkg::DIST_W + 1 - tpsq_pkg::BUF_W){1'b0}}, slack};
        have_next = have_reg;
        best_next = best_reg;
        win_next  = win_reg;
        if (ctl.init)
        begin
            have_next = 1'b0;
        end
        else if (v3_reg)
        begin
            if (ctl.nearest)
            begin
                // first point always wins; later ones must beat best + slack
                if (!have_reg || ({1'b0, d3_reg} < thresh))
                begin
                    have_next = 1'b1;
                    best_next = d3_reg;
                    win_next  = idx3_reg;
                end
            end
            else if (hit3_reg && !have_reg)
            begin
                have_next = 1'b1;
                win_next  = idx3_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            have_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= v1_next;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= pt_idx;
        dx1_reg  <= dx1_next;
        dy1_reg  <= dy1_next;
        hit1_reg <= hit1_next;
        idx2_reg <= idx1_reg;
        sqx2_reg <= sqx2_next;
        sqy2_reg <= sqy2_next;
        hit2_reg <= hit1_reg;
        idx3_reg <= idx2_reg;
        d3_reg   <= d3_next;
        hit3_reg <= hit2_reg;
        best_reg <= best_next;
        win_reg  <= win_next;
    end

    assign sts.busy  = v1_reg | v2_reg | v3_reg;
    assign sts.found = have_reg;
    assign win_idx   = win_reg;

endmodule

/* rtl/trajectory_point_store_query.sv */
// Trajectory point store: append / clear / nearest-point / time lower-bound.
// Depends on tpsq_pkg, tpsq_ram, tpsq_scan_unit.
// Done follows start in the next cycle for append, clear, empty-store queries and
//   time queries at or past the last time; other queries first scan all N stored points.
// Throughput: one command at a time, busy high while scanning, next start taken in
//   the done cycle; done is a one-cycle strobe. Async reset empties store and config.
module trajectory_point_store_query #(
    parameter int MAX_POINTS = tpsq_pkg::DEFAULT_MAX_POINTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command word
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          kind,
    input  logic signed [tpsq_pkg::TIME_W-1:0]  time_us,
    input  logic signed [tpsq_pkg::POS_W-1:0]   pos_x,
    input  logic signed [tpsq_pkg::POS_W-1:0]   pos_y,
    // result word
    output logic                                done,
    output logic [tpsq_pkg::INDEX_W-1:0]        index,
    output logic [1:0]                          status,
    output logic [tpsq_pkg::COUNT_OUT_W-1:0]    point_count,
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpsq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpsq_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);        // point address
    localparam int CW = $clog2(MAX_POINTS + 1);    // fill count
    localparam int PW = tpsq_pkg::POS_W;
    localparam int TW = tpsq_pkg::TIME_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]        count_reg, count_next;
    logic signed [TW-1:0] last_time_reg, last_time_next;
    tpsq_pkg::kind_t      kind_reg, kind_next;
    logic signed [TW-1:0] qt_reg, qt_next;
    logic signed [PW-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [AW-1:0]        issue_reg, issue_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [AW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 done_reg, done_next;
    logic [tpsq_pkg::INDEX_W-1:0] index_reg, index_next;
    tpsq_pkg::status_t    status_reg, status_next;

    logic [tpsq_pkg::EPS_W-1:0] eps_reg;
    logic [tpsq_pkg::BUF_W-1:0] buf_reg;

    logic                        ram_we, ram_re;
    logic [tpsq_pkg::PT_W-1:0]   ram_rdata;
    tpsq_pkg::scan_ctl_t         scan_ctl;
    tpsq_pkg::scan_sts_t         scan_sts;
    logic [AW-1:0]               win_idx;
    logic                        accept;
    tpsq_pkg::kind_t             kind_in;

    assign accept  = start && (state_reg == S_IDLE);
    assign kind_in = tpsq_pkg::kind_t'(kind);

    // ---------------------------------------------------------------
    // Config registers: always ready, unknown indexes are dropped.
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= '0;
            buf_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tpsq_pkg::CFG_EPS: eps_reg <= cfg_data[tpsq_pkg::EPS_W-1:0];
                tpsq_pkg::CFG_BUF: buf_reg <= cfg_data[tpsq_pkg::BUF_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer. Non-scanning commands finish in IDLE; scanning queries
    // walk addresses 0..count-1 (SCAN), then wait for the pipe (DRAIN).
    // The last stored time is kept in a flop so appends and the
    // past-the-end time check never need a RAM read.
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        last_time_next   = last_time_reg;
        kind_next        = kind_reg;
        qt_next          = qt_reg;
        qx_next          = qx_reg;
        qy_next          = qy_reg;
        issue_next       = issue_reg;
        rd_pend_next     = 1'b0;
        rd_idx_next      = rd_idx_reg;
        done_next        = 1'b0;
        index_next       = index_reg;
        status_next      = status_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        scan_ctl.init    = 1'b0;
        scan_ctl.valid   = rd_pend_reg;
        scan_ctl.nearest = (kind_reg == tpsq_pkg::K_NEAREST);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind_in;
                    qt_next    = time_us;
                    qx_next    = pos_x;
                    qy_next    = pos_y;
                    index_next = '0;
                    case (kind_in)
                        tpsq_pkg::K_CLEAR:
                        begin
                            count_next  = '0;
                            done_next   = 1'b1;
                            status_next = tpsq_pkg::ST_OK;
                        end
                        tpsq_pkg::K_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg >= CW'(MAX_POINTS))
                            begin
                                status_next = tpsq_pkg::ST_FULL;
                            end
                            else if (count_reg != '0 && time_us <= last_time_reg)
                            begin
                                status_next = tpsq_pkg::ST_ORDER;
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                count_next     = count_reg + CW'(1);
                                last_time_next = time_us;
                                status_next    = tpsq_pkg::ST_OK;
                            end
                        end
                        default:
                        begin
                            // nearest or time query
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = tpsq_pkg::ST_EMPTY;
                            end
                            else if (kind_in == tpsq_pkg::K_TIME &&
                                     time_us >= last_time_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = tpsq_pkg::ST_OK;
                                index_next  = tpsq_pkg::INDEX_W'(count_reg - CW'(1));
                            end
                            else
                            begin
                                scan_ctl.init = 1'b1;
                                issue_next    = '0;
                                state_next    = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                ram_re       = 1'b1;
                rd_pend_next = 1'b1;
                rd_idx_next  = issue_reg;
                if (CW'(issue_reg) == count_reg - CW'(1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    issue_next = issue_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                if (!rd_pend_reg && !scan_sts.busy)
                begin
                    done_next   = 1'b1;
                    status_next = tpsq_pkg::ST_OK;
                    index_next  = tpsq_pkg::INDEX_W'(win_idx);
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
            index_reg   <= '0;
            status_reg  <= tpsq_pkg::ST_OK;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
            done_reg    <= done_next;
            index_reg   <= index_next;
            status_reg  <= status_next;
        end
    end

    // payload flops, no reset needed
    always_ff @(posedge clk)
    begin
        last_time_reg <= last_time_next;
        kind_reg      <= kind_next;
        qt_reg        <= qt_next;
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        issue_reg     <= issue_next;
        rd_idx_reg    <= rd_idx_next;
    end

    // ---------------------------------------------------------------
    // Point store: one word per point, {time, x, y}.
    // ---------------------------------------------------------------
    tpsq_ram #(
        .WIDTH (tpsq_pkg::PT_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({time_us, pos_x, pos_y}),
        .re    (ram_re),
        .raddr (issue_reg),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Scan pipeline, shared by both query kinds.
    // ---------------------------------------------------------------
    tpsq_scan_unit #(
        .AW (AW)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (scan_ctl),
        .pt_idx  (rd_idx_reg),
        .pt_time (ram_rdata[tpsq_pkg::PT_W-1 -: TW]),
        .pt_x    (ram_rdata[2*PW-1 -: PW]),
        .pt_y    (ram_rdata[PW-1:0]),
        .q_time  (qt_reg),
        .q_x     (qx_reg),
        .q_y     (qy_reg),
        .eps     (eps_reg),
        .slack   (buf_reg),
        .sts     (scan_sts),
        .win_idx (win_idx)
    );

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign index       = index_reg;
    assign status      = status_reg;
    assign point_count = tpsq_pkg::COUNT_OUT_W'(count_reg);

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // a result only ever appears once the sequencer is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result word while sequencer busy");

    // fill count never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("fill count beyond capacity");

    // scan addresses stay inside the filled region
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> CW'(issue_reg) < count_reg)
        else $error("scan address past fill count");

    // clear takes effect with its result
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind_in == tpsq_pkg::K_CLEAR |=> done_reg && count_reg == '0)
        else $error("clear did not empty the store");

    // a drained scan always has a winner
    a_winner: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN && state_next == S_IDLE |-> scan_sts.found)
        else $error("scan finished without a winner");

endmodule
